@@ hw/rtl/dra_pkg.sv @@
// Shared types and constants for the dense rank assigner.
// No dependencies; imported by dra_store and dense_rank_assigner_unit.
package dra_pkg;

  // Width of the rank field on the result channel
  localparam int RANK_OUT_W = 7;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_READ  = 4'b0100,
    S_FETCH = 4'b1000
  } state_t;

  // Write enables into the value and rank memories
  typedef struct packed {
    logic val_we;
    logic rank_we;
  } store_wr_t;

endpackage

@@ hw/rtl/dra_store.sv @@
// Value and rank memories of the dense rank assigner.
// One write port and one registered read port each, shared address.
// Depends on dra_pkg (store_wr_t).
module dra_store import dra_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32,
  parameter int RANK_BITS  = 7
) (
  input  logic                         clk,
  input  store_wr_t                    wr,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic signed [VALUE_BITS-1:0] val_wdata,
  input  logic [RANK_BITS-1:0]         rank_wdata,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic signed [VALUE_BITS-1:0] val_rdata,
  output logic [RANK_BITS-1:0]         rank_rdata
);

  logic signed [VALUE_BITS-1:0] val_mem  [DEPTH];
  logic [RANK_BITS-1:0]         rank_mem [DEPTH];

  // value memory
  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[wr_addr] <= val_wdata;
    end
    val_rdata <= val_mem[rd_addr];
  end

  // rank memory, zero means no rank yet
  always_ff @(posedge clk) begin
    if (wr.rank_we) begin
      rank_mem[wr_addr] <= rank_wdata;
    end
    rank_rdata <= rank_mem[rd_addr];
  end

endmodule

@@ hw/rtl/dense_rank_assigner_unit.sv @@
// Dense rank assigner top level: load sequencer, sweep compare unit, result register.
// Depends on dra_pkg and dra_store.
//
// Values are loaded one beat per cycle; beats beyond MAX_ITEMS are dropped, and a
// marked beat ends the list even when dropped. On the marked beat the block stops
// taking input and runs sweeps over the N stored entries with one shared compare
// unit, one entry per cycle through the memory read port: each sweep hands the
// current rank to the entries equal to the previous minimum and finds the next
// minimum among the rest. Each sweep issues a read for every entry, takes in the last
// read data and then turns around to the next rank or to emission. With D distinct
// values that is D+1 sweeps.
// Ranks then leave in load order, each fetched once the output register is free, the
// final one marked with last_out. Input is taken again as soon as the final rank sits
// in the output register. Nothing needs clearing after reset.
module dense_rank_assigner_unit import dra_pkg::*; #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value_in,
  input  logic                         is_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [RANK_OUT_W-1:0]        rank_out,
  output logic                         last_out
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  state_t                       state;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             issue;
  logic [IDX_W-1:0]             pidx;
  logic                         pv;
  logic [CNT_W-1:0]             pass;
  logic                         have_min;
  logic                         found;
  logic signed [VALUE_BITS-1:0] cur_min;
  logic signed [VALUE_BITS-1:0] new_min;

  store_wr_t                    wr;
  logic [IDX_W-1:0]             wr_addr;
  logic [CNT_W-1:0]             rank_wdata;
  logic signed [VALUE_BITS-1:0] val_rd;
  logic [CNT_W-1:0]             rank_rd;

  logic in_acc;
  logic out_acc;
  logic room;
  logic issuing;
  logic unranked;
  logic hit;
  logic final_idx;

  assign in_ready  = (state == S_LOAD);
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;
  assign room      = (count < CNT_W'(MAX_ITEMS));
  assign issuing   = (issue < count);
  assign unranked  = (rank_rd == '0);
  assign hit       = pv & unranked & have_min & (val_rd == cur_min);
  assign final_idx = (issue == count - CNT_W'(1));

  // memory write port: load stores value and clears rank, sweep writes ranks
  always_comb begin
    wr.val_we  = in_acc & room;
    wr.rank_we = (in_acc & room) | ((state == S_SWEEP) & hit);
    wr_addr    = (state == S_LOAD) ? count[IDX_W-1:0] : pidx;
    rank_wdata = (state == S_LOAD) ? '0 : pass;
  end

  dra_store #(
    .DEPTH      (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS),
    .RANK_BITS  (CNT_W)
  ) u_store (
    .clk        (clk),
    .wr         (wr),
    .wr_addr    (wr_addr),
    .val_wdata  (value_in),
    .rank_wdata (rank_wdata),
    .rd_addr    (issue[IDX_W-1:0]),
    .val_rdata  (val_rd),
    .rank_rdata (rank_rd)
  );

  // sequencer, sweep compare unit and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      issue     <= '0;
      pv        <= 1'b0;
      pass      <= '0;
      have_min  <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_acc) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end
            if (is_last) begin
              state    <= S_SWEEP;
              issue    <= '0;
              pv       <= 1'b0;
              pass     <= '0;
              have_min <= 1'b0;
              found    <= 1'b0;
            end
          end
        end
        S_SWEEP: begin
          // issue reads; data returns in the next cycle tagged by pidx
          pv <= issuing;
          if (issuing) begin
            issue <= issue + CNT_W'(1);
            pidx  <= issue[IDX_W-1:0];
          end
          // next minimum among entries still unranked after this sweep
          if (pv && unranked && !hit) begin
            if (!found || (val_rd < new_min)) begin
              new_min <= val_rd;
              found   <= 1'b1;
            end
          end
          // sweep done: next rank or emit
          if (!issuing && !pv) begin
            issue <= '0;
            if (found) begin
              pass     <= pass + CNT_W'(1);
              cur_min  <= new_min;
              have_min <= 1'b1;
              found    <= 1'b0;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (!out_valid) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          rank_out  <= RANK_OUT_W'(rank_rd);
          last_out  <= final_idx;
          out_valid <= 1'b1;
          if (final_idx) begin
            state    <= S_LOAD;
            count    <= '0;
            issue    <= '0;
            pass     <= '0;
            have_min <= 1'b0;
          end else begin
            issue <= issue + CNT_W'(1);
            state <= S_READ;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // rank handed out never exceeds the number of stored entries
  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    pass <= count)
    else $error("rank counter beyond entry count");

  // a sweep rank write always lands on a stored entry
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) && wr.rank_we |-> (CNT_W'(pidx) < count))
    else $error("rank write outside stored entries");

  // the result register is only loaded when it was free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> !out_valid)
    else $error("result register overwritten");

  // input is never taken while ranks of a list remain to be fetched
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) && !final_idx |=> !in_ready)
    else $error("input accepted mid emission");

endmodule
